// ===== design/twspi_pkg.sv =====
// Shared types and constants for the three-wire SPI register master.
package twspi_pkg;

    localparam int NUM_CONVERTERS_DEF = 4;

    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;

    localparam logic [3:0] PIN_IDLE     = 4'h9;
    localparam logic [3:0] PIN_SEL_LOW  = 4'h1;
    localparam logic [3:0] PIN_CLK      = 4'h4;
    localparam logic [3:0] PIN_RELEASED = 4'h0;
    localparam logic [5:0] FRAME_LAST   = 6'd49;
    localparam logic [3:0] ADDR_SLOTS   = 4'd8;
    localparam logic [1:0] SUB_LAST     = 2'd2;
    localparam logic [1:0] SUB_RISE     = 2'd1;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_READ  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_CHAN = 2'd1,
        STATUS_BUSY     = 2'd2
    } status_t;

    typedef struct packed {
        func_t      func;
        logic [3:0] channel;
        logic [6:0] addr;
        logic [7:0] wdata;
        logic       sdio_in;
    } item_t;

    typedef struct packed {
        logic [3:0] port_sel;
        logic [3:0] pin_word;
        logic       done_res;
        logic [7:0] read_data;
        logic       read_valid;
        status_t    status;
    } result_t;

    typedef struct packed {
        logic       busy;
        logic [5:0] phase;
        logic [1:0] sub;
        logic [3:0] slot;
    } frame_status_t;

endpackage

// ===== design/twspi_frame.sv =====
// Frame state registers and the per-request phase logic of the SPI master.
module twspi_frame #(
    parameter int NUM_CONVERTERS = twspi_pkg::NUM_CONVERTERS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      advance,
    input  twspi_pkg::item_t          item,
    output twspi_pkg::result_t        res,
    output twspi_pkg::frame_status_t  fstat
);
    import twspi_pkg::*;

    localparam logic [3:0] NUM_CONV = 4'(NUM_CONVERTERS);

    logic        busy_reg, busy_next;
    logic [5:0]  phase_reg, phase_next;
    logic [1:0]  sub_reg, sub_next;
    logic [3:0]  slot_reg, slot_next;
    logic        is_read_reg, is_read_next;
    logic [3:0]  chan_reg, chan_next;
    logic [15:0] out_shift_reg, out_shift_next;
    logic [7:0]  in_shift_reg, in_shift_next;
    logic [3:0]  held_reg, held_next;
    logic        out_bit;

    assign out_bit = out_shift_reg[4'd15 - slot_reg];

    always_comb begin
        busy_next      = busy_reg;
        phase_next     = phase_reg;
        sub_next       = sub_reg;
        slot_next      = slot_reg;
        is_read_next   = is_read_reg;
        chan_next      = chan_reg;
        out_shift_next = out_shift_reg;
        in_shift_next  = in_shift_reg;
        held_next      = held_reg;
        res.done_res   = 1'b0;
        res.read_valid = 1'b0;
        res.read_data  = 8'd0;
        res.status     = STATUS_OK;
        case (item.func)
            FUNC_WRITE, FUNC_READ: begin
                if (busy_reg) begin
                    res.status = STATUS_BUSY;
                end else if (item.channel == 4'd0 || item.channel > NUM_CONV) begin
                    res.status = STATUS_BAD_CHAN;
                end else begin
                    busy_next      = 1'b1;
                    phase_next     = 6'd0;
                    sub_next       = 2'd0;
                    slot_next      = 4'd0;
                    is_read_next   = (item.func == FUNC_READ);
                    chan_next      = item.channel;
                    out_shift_next = {(item.func == FUNC_READ), item.addr,
                                      (item.func == FUNC_READ) ? 8'd0 : item.wdata};
                    in_shift_next  = 8'd0;
                end
            end
            FUNC_TICK: begin
                if (busy_reg) begin
                    if (phase_reg == 6'd0) begin
                        held_next = PIN_SEL_LOW;
                    end else if (phase_reg >= FRAME_LAST) begin
                        held_next      = PIN_IDLE;
                        res.done_res   = 1'b1;
                        res.read_valid = is_read_reg;
                        res.read_data  = is_read_reg ? in_shift_reg : 8'd0;
                        busy_next      = 1'b0;
                    end else begin
                        if (is_read_reg && slot_reg >= ADDR_SLOTS) begin
                            if (sub_reg == SUB_RISE) begin
                                in_shift_next = {in_shift_reg[6:0], item.sdio_in};
                                held_next     = PIN_CLK;
                            end else begin
                                held_next = PIN_RELEASED;
                            end
                        end else begin
                            held_next = PIN_SEL_LOW | {2'b00, out_bit, 1'b0}
                                      | ((sub_reg == SUB_RISE) ? PIN_CLK : 4'h0);
                        end
                        if (sub_reg == SUB_LAST) begin
                            sub_next  = 2'd0;
                            slot_next = slot_reg + 4'd1;
                        end else begin
                            sub_next = sub_reg + 2'd1;
                        end
                    end
                    phase_next = busy_next ? phase_reg + 6'd1 : 6'd0;
                end
            end
            default: begin
            end
        endcase
        res.port_sel = (chan_next == 4'd0) ? 4'd0 : chan_next - 4'd1;
        res.pin_word = held_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            phase_reg     <= 6'd0;
            sub_reg       <= 2'd0;
            slot_reg      <= 4'd0;
            is_read_reg   <= 1'b0;
            chan_reg      <= 4'd0;
            out_shift_reg <= 16'd0;
            in_shift_reg  <= 8'd0;
            held_reg      <= PIN_IDLE;
        end else if (advance) begin
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            sub_reg       <= sub_next;
            slot_reg      <= slot_next;
            is_read_reg   <= is_read_next;
            chan_reg      <= chan_next;
            out_shift_reg <= out_shift_next;
            in_shift_reg  <= in_shift_next;
            held_reg      <= held_next;
        end
    end

    assign fstat = '{busy: busy_reg, phase: phase_reg, sub: sub_reg, slot: slot_reg};

endmodule

// ===== design/three_wire_spi_register_master_core.sv =====
// Three-wire SPI register master: stream ports, input and result registers.
// Throughput: one request per cycle while the result port does not stall;
// the phase counter steps once per tick.
// Each request passes the input register, then the frame logic into the result register.
// Reset (aresetn low, synchronous): idle, no frame, pins held at the idle word 9.
// Both register stages come out of reset empty.
module three_wire_spi_register_master_core #(
    parameter int NUM_CONVERTERS = twspi_pkg::NUM_CONVERTERS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // channel[3:0], addr[10:4], wdata[18:11], sdio_in[19], zero fill
    input  logic [twspi_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // func[1:0]
    input  logic [twspi_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // port_sel[3:0], pin_word[7:4], read_data[15:8], read_valid[16],
    // status[18:17], zero fill
    output logic [twspi_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // done_res
    output logic                              m_axis_tlast
);
    import twspi_pkg::*;

    logic          in_valid_reg;
    item_t         in_item_reg;
    logic          out_valid_reg;
    result_t       out_res_reg;
    logic          advance;
    result_t       res;
    frame_status_t fstat;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_item_reg <= '{func: func_t'(s_axis_tuser),
                             channel: s_axis_tdata[3:0],
                             addr: s_axis_tdata[10:4],
                             wdata: s_axis_tdata[18:11],
                             sdio_in: s_axis_tdata[19]};
        end
    end

    twspi_frame #(
        .NUM_CONVERTERS(NUM_CONVERTERS)
    ) u_frame (
        .aclk   (aclk),
        .aresetn(aresetn),
        .advance(advance),
        .item   (in_item_reg),
        .res    (res),
        .fstat  (fstat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_res_reg.done_res;
    assign m_axis_tdata  = {5'd0, out_res_reg.status, out_res_reg.read_valid,
                            out_res_reg.read_data, out_res_reg.pin_word,
                            out_res_reg.port_sel};

`ifndef NO_ASSERTIONS
    a_idle_phase_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !fstat.busy |-> (fstat.phase == 6'd0))
        else $error("phase counter nonzero while idle");

    a_sub_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fstat.sub != 2'd3)
        else $error("slot sub-phase out of range");

    a_read_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_res_reg.read_valid) |->
            (out_res_reg.done_res && out_res_reg.pin_word == PIN_IDLE))
        else $error("read result outside closing phase");

    a_done_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res.done_res) |=> !fstat.busy)
        else $error("frame still busy after done");
`endif

endmodule

// ===== sim/three_wire_spi_register_master_core_test.sv =====
// Self-checking stream testbench for the three-wire SPI register master core.
module three_wire_spi_register_master_core_test;
    import twspi_pkg::*;

    localparam int         CONVERTERS   = NUM_CONVERTERS_DEF;
    localparam logic [1:0] FUNC_NOP     = 2'd3;
    localparam int         RANDOM_END   = 1250;
    localparam int         HOLD_CYCLES  = 80;
    localparam int         QUIET_LIMIT  = 1000;
    localparam int         SETTLE       = 8;

    logic                  aclk;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    three_wire_spi_register_master_core #(
        .NUM_CONVERTERS(CONVERTERS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // frame state of the predictor
    logic        frame_busy    = 1'b0;
    logic [5:0]  frame_phase   = '0;
    logic        frame_is_read = 1'b0;
    logic [3:0]  frame_chan    = '0;
    logic [15:0] tx_word       = '0;
    logic [7:0]  rx_byte       = '0;
    logic [3:0]  pins_held     = PIN_IDLE;

    result_t pin_phase_q[$];

    int  items_sent    = 0;
    int  writes_done   = 0;
    int  reads_done    = 0;
    int  busy_refused  = 0;
    int  chan_refused  = 0;
    int  fail_count    = 0;
    int  quiet_cycles  = 0;
    int  hold_requests = 0;
    int  holds_done    = 0;
    int  hold_left     = 0;
    int  burst_left    = 0;
    bit  src_gaps      = 1'b0;
    bit  sink_gaps     = 1'b0;

    function automatic result_t spi_phase_predict(logic [1:0] f, logic [3:0] ch,
                                                  logic [6:0] addr, logic [7:0] wdata,
                                                  logic sdio);
        result_t    r;
        logic [5:0] p;
        logic [3:0] slot;
        logic [1:0] sub;
        logic       bit_out;
        r = '0;
        r.status = STATUS_OK;
        if (f == FUNC_WRITE || f == FUNC_READ) begin
            if (frame_busy) begin
                r.status = STATUS_BUSY;
                busy_refused++;
            end else if (ch < 1 || ch > CONVERTERS) begin
                r.status = STATUS_BAD_CHAN;
                chan_refused++;
            end else begin
                frame_busy    = 1'b1;
                frame_phase   = '0;
                frame_is_read = (f == FUNC_READ);
                frame_chan    = ch;
                tx_word       = {frame_is_read, addr, frame_is_read ? 8'h00 : wdata};
                rx_byte       = '0;
            end
        end else if (f == FUNC_TICK && frame_busy) begin
            p = frame_phase;
            if (p == 0) begin
                pins_held = PIN_SEL_LOW;
            end else if (p >= FRAME_LAST) begin
                pins_held  = PIN_IDLE;
                r.done_res = 1'b1;
                if (frame_is_read) begin
                    r.read_valid = 1'b1;
                    r.read_data  = rx_byte;
                    reads_done++;
                end else begin
                    writes_done++;
                end
                frame_busy = 1'b0;
            end else begin
                slot = 4'((p - 1) / 3);
                sub  = 2'((p - 1) % 3);
                if (frame_is_read && slot >= ADDR_SLOTS) begin
                    if (sub == SUB_RISE) begin
                        rx_byte   = {rx_byte[6:0], sdio};
                        pins_held = PIN_CLK;
                    end else begin
                        pins_held = PIN_RELEASED;
                    end
                end else begin
                    bit_out   = tx_word[15 - slot];
                    pins_held = PIN_SEL_LOW | {2'b00, bit_out, 1'b0};
                    if (sub == SUB_RISE)
                        pins_held = pins_held | PIN_CLK;
                end
            end
            frame_phase = frame_busy ? p + 6'd1 : 6'd0;
        end
        r.port_sel = (frame_chan == 0) ? 4'd0 : frame_chan - 4'd1;
        r.pin_word = pins_held;
        return r;
    endfunction

    // result side: checking, ready pattern and the quiet-cycle count
    always @(posedge aclk) begin : result_sink
        result_t got;
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.port_sel   = m_axis_tdata[3:0];
            got.pin_word   = m_axis_tdata[7:4];
            got.read_data  = m_axis_tdata[15:8];
            got.read_valid = m_axis_tdata[16];
            got.status     = status_t'(m_axis_tdata[18:17]);
            got.done_res   = m_axis_tlast;
            if (pin_phase_q.size() == 0) begin
                $error("unexpected result %h", m_axis_tdata);
                fail_count++;
            end else begin
                want = pin_phase_q.pop_front();
                if (got.port_sel != want.port_sel) begin
                    $error("port_sel: expected %0d, got %0d", want.port_sel, got.port_sel);
                    fail_count++;
                end
                if (got.pin_word != want.pin_word) begin
                    $error("pin_word: expected %h, got %h", want.pin_word, got.pin_word);
                    fail_count++;
                end
                if (got.done_res != want.done_res) begin
                    $error("done_res: expected %b, got %b", want.done_res, got.done_res);
                    fail_count++;
                end
                if (got.read_data != want.read_data) begin
                    $error("read_data: expected %h, got %h", want.read_data, got.read_data);
                    fail_count++;
                end
                if (got.read_valid != want.read_valid) begin
                    $error("read_valid: expected %b, got %b", want.read_valid,
                           got.read_valid);
                    fail_count++;
                end
                if (got.status != want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    fail_count++;
                end
            end
        end
        if (!aresetn || (m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (holds_done != hold_requests) begin
            holds_done    <= holds_done + 1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (burst_left != 0) begin
            burst_left    <= burst_left - 1;
            m_axis_tready <= 1'b0;
        end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
            burst_left    <= $urandom_range(0, 17);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb: failure");
        $finish;
    end

    task automatic send_req(logic [1:0] f, logic [3:0] ch, logic [6:0] addr,
                            logic [7:0] wdata, logic sdio);
        int gap;
        if (src_gaps && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= {4'h0, sdio, wdata, addr, ch};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        pin_phase_q.push_back(spi_phase_predict(f, ch, addr, wdata, sdio));
        items_sent++;
    endtask

    task automatic send_noise();
        send_req(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pin_phase_q.size() != 0) @(posedge aclk);
    endtask

    // ticks until the open frame closes; noise lands between ticks
    task automatic finish_frame(bit noisy, bit rand_sdio, bit level);
        while (frame_busy) begin
            if (noisy && $urandom_range(0, 15) == 0)
                send_noise();
            else
                send_req(FUNC_TICK, 4'($urandom_range(0, 15)), 7'($urandom_range(0, 127)),
                         8'($urandom_range(0, 255)),
                         rand_sdio ? 1'($urandom_range(0, 1)) : level);
        end
    endtask

    task automatic run_frame(logic [1:0] f, logic [3:0] ch, logic [6:0] addr,
                             logic [7:0] wdata, bit noisy);
        send_req(f, ch, addr, wdata, 1'($urandom_range(0, 1)));
        finish_frame(noisy, 1'b1, 1'b0);
    endtask

    task automatic run_random_frame(bit noisy);
        run_frame(2'($urandom_range(1, 2)), 4'($urandom_range(1, CONVERTERS)),
                  7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), noisy);
    endtask

    task automatic test_idle_requests();
        send_req(FUNC_TICK, 4'd0, 7'd0, 8'd0, 1'b0);
        send_req(FUNC_NOP, 4'd2, 7'd0, 8'd0, 1'b1);
        send_req(FUNC_WRITE, 4'd0, 7'h7f, 8'hff, 1'b1);
        send_req(FUNC_READ, 4'd5, 7'h00, 8'h00, 1'b0);
        send_req(FUNC_WRITE, 4'd15, 7'h7f, 8'hff, 1'b1);
        send_req(FUNC_READ, 4'd8, 7'h2a, 8'h55, 1'b0);
        drain_results();
    endtask

    task automatic test_write_frame();
        send_req(FUNC_WRITE, 4'd4, 7'h7f, 8'hff, 1'b0);
        send_req(FUNC_TICK, 4'd0, 7'd0, 8'd0, 1'b0);
        // refused while busy, bad channel or not
        send_req(FUNC_WRITE, 4'd0, 7'h00, 8'h00, 1'b0);
        send_req(FUNC_READ, 4'd2, 7'h11, 8'h22, 1'b1);
        send_req(FUNC_NOP, 4'd1, 7'h00, 8'h00, 1'b0);
        finish_frame(1'b0, 1'b1, 1'b0);
        run_frame(FUNC_WRITE, 4'd1, 7'h00, 8'h00, 1'b0);
        drain_results();
    endtask

    task automatic test_read_frames();
        send_req(FUNC_READ, 4'd1, 7'h00, 8'hff, 1'b1);
        finish_frame(1'b0, 1'b0, 1'b1);
        send_req(FUNC_READ, 4'd3, 7'h55, 8'h00, 1'b0);
        finish_frame(1'b0, 1'b0, 1'b0);
        run_frame(FUNC_READ, 4'd2, 7'h2a, 8'h00, 1'b0);
        drain_results();
    endtask

    task automatic test_backpressure();
        src_gaps = 1'b0;
        sink_gaps <= 1'b0;
        hold_requests <= hold_requests + 1;
        run_frame(FUNC_READ, 4'd4, 7'($urandom_range(0, 127)), 8'h00, 1'b1);
        drain_results();
    endtask

    task automatic test_random_traffic();
        int mode;
        int pick;
        int n;
        while (items_sent < RANDOM_END) begin
            mode = $urandom_range(0, 3);
            src_gaps = mode[0];
            sink_gaps <= mode[1];
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                run_random_frame(1'b1);
            end else if (pick < 9) begin
                n = $urandom_range(1, 6);
                repeat (n) send_noise();
            end else begin
                drain_results();
            end
        end
    endtask

    task automatic test_steady_stream();
        src_gaps = 1'b0;
        sink_gaps <= 1'b0;
        finish_frame(1'b0, 1'b1, 1'b0);
        repeat (3) run_random_frame(1'b0);
        drain_results();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_idle_requests();
        test_write_frame();
        test_read_frames();
        test_backpressure();
        test_random_traffic();
        test_steady_stream();
        repeat (SETTLE) @(posedge aclk);
        $display("summary: %0d requests sent, %0d write and %0d read frames completed",
                 items_sent, writes_done, reads_done);
        $display("summary: %0d refused while busy, %0d refused for a bad channel",
                 busy_refused, chan_refused);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
design/twspi_pkg.sv
design/twspi_frame.sv
design/three_wire_spi_register_master_core.sv
sim/three_wire_spi_register_master_core_test.sv
